@@ rtl/core/assert_macros.svh @@
// ----------------------------------------------------------------------------
// assertion macros
// shared concurrent assertion wrappers, empty when SYNTHESIS is defined
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// checked only while out of reset
`define ASSERT_ON(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// checked at every edge, reset included
`define ASSERT_ALWAYS(label, clk, prop, msg) \
	label: assert property (@(posedge clk) prop) else $error(msg);

`else

`define ASSERT_ON(label, clk, rst_n, prop, msg)
`define ASSERT_ALWAYS(label, clk, prop, msg)

`endif

`endif

@@ rtl/core/y86cd_pkg.sv @@
// ----------------------------------------------------------------------------
// y86cd_pkg
// types and encodings shared by the y86-64 classify and decode block
// ----------------------------------------------------------------------------
`default_nettype none

package y86cd_pkg;

	localparam int ADDR_W = 64;
	localparam int CONST_W = 64;

	localparam logic [1:0] KIND_INSN = 2'd0;
	localparam logic [1:0] KIND_QUAD = 2'd1;
	localparam logic [1:0] KIND_BYTE = 2'd2;

	localparam logic [3:0] NO_REG = 4'hF;
	localparam logic [3:0] MAX_REG = 4'hE;
	localparam logic [3:0] MAX_FN = 4'h6;

	localparam logic [7:0] OP_HALT = 8'h00;
	localparam logic [7:0] OP_NOP = 8'h10;
	localparam logic [7:0] OP_IRMOVQ = 8'h30;
	localparam logic [7:0] OP_RMMOVQ = 8'h40;
	localparam logic [7:0] OP_MRMOVQ = 8'h50;
	localparam logic [7:0] OP_CALL = 8'h80;
	localparam logic [7:0] OP_RET = 8'h90;
	localparam logic [7:0] OP_PUSHQ = 8'hA0;
	localparam logic [7:0] OP_POPQ = 8'hB0;

	localparam logic [3:0] HI_CMOV = 4'h2;
	localparam logic [3:0] HI_OPQ = 4'h6;
	localparam logic [3:0] HI_JXX = 4'h7;

	localparam logic [3:0] LEN_ONE = 4'd1;
	localparam logic [3:0] LEN_TWO = 4'd2;
	localparam logic [3:0] LEN_QUAD = 4'd8;
	localparam logic [3:0] LEN_JUMP = 4'd9;
	localparam logic [3:0] LEN_LONG = 4'd10;

	localparam logic [3:0] AVAIL_QUAD = 4'd7;
	localparam logic [3:0] AVAIL_JUMP = 4'd8;
	localparam logic [3:0] AVAIL_LONG = 4'd9;

	typedef struct packed {
		logic [7:0]        first_byte;
		logic [63:0]       following_bytes;
		logic [7:0]        ninth_following_byte;
		logic [3:0]        bytes_available;
		logic [ADDR_W-1:0] address;
	} window_t;

	typedef struct packed {
		logic [1:0]         item_kind;
		logic [7:0]         opcode;
		logic [3:0]         reg_a;
		logic [3:0]         reg_b;
		logic [CONST_W-1:0] constant;
		logic [3:0]         length;
		logic [ADDR_W-1:0]  next_address;
	} result_t;

endpackage

`default_nettype wire

@@ rtl/core/y86cd_decode.sv @@
// ----------------------------------------------------------------------------
// y86cd_decode
// classifies one byte window as instruction, quad word or byte word
// ----------------------------------------------------------------------------
`default_nettype none

module y86cd_decode (
	input  y86cd_pkg::window_t win,
	output y86cd_pkg::result_t res
);
	import y86cd_pkg::*;

	always_comb begin
		logic [7:0]  b0;
		logic [3:0]  hi;
		logic [3:0]  fn;
		logic [3:0]  ra;
		logic [3:0]  rb;
		logic [3:0]  avail;
		logic [63:0] imm;
		logic        has_byte;

		b0 = win.first_byte;
		hi = b0[7:4];
		fn = b0[3:0];
		ra = win.following_bytes[7:4];
		rb = win.following_bytes[3:0];
		avail = win.bytes_available;
		imm = {win.ninth_following_byte, win.following_bytes[63:8]};
		has_byte = (avail != 4'd0);

		// data unless a rule below matches
		res.opcode = 8'h00;
		res.reg_a = NO_REG;
		res.reg_b = NO_REG;
		if ((win.address[2:0] == 3'd0) && (avail >= AVAIL_QUAD)) begin
			res.item_kind = KIND_QUAD;
			res.constant = {win.following_bytes[55:0], b0};
			res.length = LEN_QUAD;
		end else begin
			res.item_kind = KIND_BYTE;
			res.constant = {56'd0, b0};
			res.length = LEN_ONE;
		end

		priority if (b0 == OP_HALT || b0 == OP_NOP || b0 == OP_RET) begin
			res.item_kind = KIND_INSN;
			res.opcode = b0;
			res.constant = '0;
			res.length = LEN_ONE;
		end else if ((hi == HI_CMOV || hi == HI_OPQ) && fn <= MAX_FN) begin
			if (has_byte && ra <= MAX_REG && rb <= MAX_REG) begin
				res.item_kind = KIND_INSN;
				res.opcode = b0;
				res.reg_a = ra;
				res.reg_b = rb;
				res.constant = '0;
				res.length = LEN_TWO;
			end
		end else if (b0 == OP_IRMOVQ) begin
			if (avail >= AVAIL_LONG && ra == NO_REG && rb <= MAX_REG) begin
				res.item_kind = KIND_INSN;
				res.opcode = b0;
				res.reg_b = rb;
				res.constant = imm;
				res.length = LEN_LONG;
			end
		end else if (b0 == OP_RMMOVQ || b0 == OP_MRMOVQ) begin
			if (avail >= AVAIL_LONG && ra <= MAX_REG && rb <= MAX_REG) begin
				res.item_kind = KIND_INSN;
				res.opcode = b0;
				res.reg_a = ra;
				res.reg_b = rb;
				res.constant = imm;
				res.length = LEN_LONG;
			end
		end else if (hi == HI_JXX || b0 == OP_CALL) begin
			if (avail >= AVAIL_JUMP && (b0 == OP_CALL || fn <= MAX_FN)) begin
				res.item_kind = KIND_INSN;
				res.opcode = b0;
				res.constant = win.following_bytes;
				res.length = LEN_JUMP;
			end
		end else if (b0 == OP_PUSHQ || b0 == OP_POPQ) begin
			if (has_byte && ra <= MAX_REG) begin
				res.item_kind = KIND_INSN;
				res.opcode = b0;
				res.reg_a = ra;
				res.constant = '0;
				res.length = LEN_TWO;
			end
		end else begin
		end

		res.next_address = win.address + {{(ADDR_W-4){1'b0}}, res.length};
	end

endmodule

`default_nettype wire

@@ rtl/core/y86_instruction_classify_decode.sv @@
// ----------------------------------------------------------------------------
// y86_instruction_classify_decode
// decodes a window of y86-64 code bytes into one instruction or data word
//
// input channel: in_valid / in_stall carry one window word per handshake
// (first byte, next nine bytes, byte count, address). output channel:
// out_valid / out_stall carry one decoded word (kind, opcode, registers,
// constant, length, next address).
// a word is taken into the input register and decoded into the result
// register, which drives the outputs. throughput is one word per cycle
// unless the output stalls, set by the single input and result registers.
// reset clears both stage valid bits, so no word is shown after reset.
// a stall on the output holds the result register; the input register
// keeps taking words while the result register is free, and in_stall rises
// only when both stages are full and the output is stalled.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module y86_instruction_classify_decode (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire logic [7:0]  first_byte,
	input  wire logic [63:0] following_bytes,
	input  wire logic [7:0]  ninth_following_byte,
	input  wire logic [3:0]  bytes_available,
	input  wire logic [63:0] address,
	output logic             out_valid,
	input  wire logic        out_stall,
	output logic [1:0]       item_kind,
	output logic [7:0]       opcode,
	output logic [3:0]       reg_a,
	output logic [3:0]       reg_b,
	output logic [63:0]      constant,
	output logic [3:0]       length,
	output logic [63:0]      next_address
);
	import y86cd_pkg::*;

	logic    v_s1;
	logic    v_s2;
	window_t win_s1;
	result_t res_s2;
	result_t res_d;
	logic    adv_s1;
	logic    adv_s2;
	logic    full_stalled;
	logic    data_word_ok;

	assign adv_s2 = !v_s2 || !out_stall;
	assign adv_s1 = !v_s1 || adv_s2;
	assign in_stall = !adv_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			if (adv_s1)
				v_s1 <= in_valid;
			if (adv_s2)
				v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1 && in_valid) begin
			win_s1.first_byte <= first_byte;
			win_s1.following_bytes <= following_bytes;
			win_s1.ninth_following_byte <= ninth_following_byte;
			win_s1.bytes_available <= bytes_available;
			win_s1.address <= address;
		end
		if (adv_s2 && v_s1)
			res_s2 <= res_d;
	end

	y86cd_decode u_decode (
		.win (win_s1),
		.res (res_d)
	);

	assign out_valid = v_s2;
	assign item_kind = res_s2.item_kind;
	assign opcode = res_s2.opcode;
	assign reg_a = res_s2.reg_a;
	assign reg_b = res_s2.reg_b;
	assign constant = res_s2.constant;
	assign length = res_s2.length;
	assign next_address = res_s2.next_address;

	assign full_stalled = v_s1 && v_s2 && out_stall;
	assign data_word_ok = (item_kind == KIND_INSN) ||
		(opcode == 8'h00 && reg_a == NO_REG && reg_b == NO_REG &&
		(length == LEN_QUAD || length == LEN_ONE));

	// no word appears right after reset
	`ASSERT_ALWAYS(a_no_word_after_reset, clk, !arst_n |=> !out_valid, "word shown after reset")

	// a full pipe under stall keeps both words
	`ASSERT_ON(a_full_holds, clk, arst_n, full_stalled |=> v_s1 && v_s2, "word lost under stall")

	// data words carry no opcode or registers and fixed lengths
	`ASSERT_ON(a_data_fields, clk, arst_n, out_valid |-> data_word_ok, "bad data word fields")

endmodule

`default_nettype wire

@@ sim/tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// self-checking bench for the y86-64 classify and decode block
//
// directed windows cover every opcode class, register and count limits,
// data fallback and address wrap; random windows (mostly well-formed
// encodings) follow under changing input and output idle rates and one
// long output hold-off. each decoded word is checked field by field
// against an in-bench decoder, in order.
// ----------------------------------------------------------------------------
module tb;
	import y86cd_pkg::*;

	localparam int HOLD_CYCLES = 80;
	localparam int MAX_PRINTS = 40;

	logic        clk;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_stall;
	logic [7:0]  first_byte = '0;
	logic [63:0] following_bytes = '0;
	logic [7:0]  ninth_following_byte = '0;
	logic [3:0]  bytes_available = '0;
	logic [63:0] address = '0;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic [1:0]  item_kind;
	logic [7:0]  opcode;
	logic [3:0]  reg_a;
	logic [3:0]  reg_b;
	logic [63:0] constant;
	logic [3:0]  length;
	logic [63:0] next_address;

	result_t expected_decodes[$];
	int mismatch_count = 0;
	int send_idle_pct = 0;
	int recv_idle_pct = 0;
	int hold_reqs = 0;
	int hold_seen = 0;
	int hold_left = 0;

	y86_instruction_classify_decode dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.first_byte(first_byte),
		.following_bytes(following_bytes),
		.ninth_following_byte(ninth_following_byte),
		.bytes_available(bytes_available),
		.address(address),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.item_kind(item_kind),
		.opcode(opcode),
		.reg_a(reg_a),
		.reg_b(reg_b),
		.constant(constant),
		.length(length),
		.next_address(next_address)
	);

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	initial begin
		#2_000_000;
		$display("y86_instruction_classify_decode: mismatch");
		$finish;
	end

	function automatic result_t decode_window(input window_t w);
		result_t r;
		logic [3:0] hi, fn, ra, rb, avail;
		logic [63:0] imm;
		logic insn, direct_byte;
		hi = w.first_byte[7:4];
		fn = w.first_byte[3:0];
		ra = w.following_bytes[7:4];
		rb = w.following_bytes[3:0];
		avail = (w.bytes_available > AVAIL_LONG) ? AVAIL_LONG : w.bytes_available;
		imm = {w.ninth_following_byte, w.following_bytes[63:8]};
		insn = 1'b0;
		direct_byte = 1'b0;
		r.item_kind = KIND_INSN;
		r.opcode = w.first_byte;
		r.reg_a = NO_REG;
		r.reg_b = NO_REG;
		r.constant = '0;
		r.length = LEN_ONE;
		if (w.first_byte == OP_HALT || w.first_byte == OP_NOP || w.first_byte == OP_RET) begin
			insn = 1'b1;
		end else if ((hi == HI_CMOV || hi == HI_OPQ) && fn <= MAX_FN) begin
			if (avail == 0) begin
				direct_byte = 1'b1;
			end else if (ra <= MAX_REG && rb <= MAX_REG) begin
				insn = 1'b1;
				r.reg_a = ra;
				r.reg_b = rb;
				r.length = LEN_TWO;
			end
		end else if (w.first_byte == OP_IRMOVQ) begin
			if (avail >= AVAIL_LONG && ra == NO_REG && rb <= MAX_REG) begin
				insn = 1'b1;
				r.reg_b = rb;
				r.constant = imm;
				r.length = LEN_LONG;
			end
		end else if (w.first_byte == OP_RMMOVQ || w.first_byte == OP_MRMOVQ) begin
			if (avail >= AVAIL_LONG && ra <= MAX_REG && rb <= MAX_REG) begin
				insn = 1'b1;
				r.reg_a = ra;
				r.reg_b = rb;
				r.constant = imm;
				r.length = LEN_LONG;
			end
		end else if (hi == HI_JXX || w.first_byte == OP_CALL) begin
			if (avail >= AVAIL_JUMP && (w.first_byte == OP_CALL || fn <= MAX_FN)) begin
				insn = 1'b1;
				r.constant = w.following_bytes;
				r.length = LEN_JUMP;
			end
		end else if (w.first_byte == OP_PUSHQ || w.first_byte == OP_POPQ) begin
			if (avail == 0) begin
				direct_byte = 1'b1;
			end else if (ra <= MAX_REG) begin
				insn = 1'b1;
				r.reg_a = ra;
				r.length = LEN_TWO;
			end
		end
		if (!insn) begin
			r.opcode = '0;
			r.reg_a = NO_REG;
			r.reg_b = NO_REG;
			if (!direct_byte && w.address[2:0] == 3'b000 && avail >= AVAIL_QUAD) begin
				r.item_kind = KIND_QUAD;
				r.constant = {w.following_bytes[55:0], w.first_byte};
				r.length = LEN_QUAD;
			end else begin
				r.item_kind = KIND_BYTE;
				r.constant = {56'd0, w.first_byte};
				r.length = LEN_ONE;
			end
		end
		r.next_address = w.address + 64'(r.length);
		return r;
	endfunction

	function automatic window_t make_window(input logic [7:0] b0, input logic [63:0] nx,
			input logic [7:0] b9, input logic [3:0] avail, input logic [63:0] addr);
		window_t w;
		w.first_byte = b0;
		w.following_bytes = nx;
		w.ninth_following_byte = b9;
		w.bytes_available = avail;
		w.address = addr;
		return w;
	endfunction

	function automatic window_t random_window();
		window_t w;
		logic [3:0] fn;
		w.first_byte = 8'($urandom);
		w.following_bytes = {$urandom, $urandom};
		w.ninth_following_byte = 8'($urandom);
		w.address = {$urandom, $urandom};
		if ($urandom_range(1, 0) != 0)
			w.address[2:0] = 3'b000;
		if ($urandom_range(9, 0) == 0)
			w.address[63:4] = '1;
		w.bytes_available = ($urandom_range(4, 0) != 0) ? AVAIL_LONG : 4'($urandom_range(15, 0));
		fn = 4'($urandom_range(6, 0));
		if ($urandom_range(9, 0) < 7) begin
			case ($urandom_range(10, 0))
				0: w.first_byte = ($urandom_range(2, 0) == 0) ? OP_HALT :
					($urandom_range(1, 0) != 0) ? OP_NOP : OP_RET;
				1: w.first_byte = {HI_CMOV, fn};
				2: w.first_byte = {HI_OPQ, fn};
				3: w.first_byte = OP_IRMOVQ;
				4: w.first_byte = OP_RMMOVQ;
				5: w.first_byte = OP_MRMOVQ;
				6: w.first_byte = {HI_JXX, fn};
				7: w.first_byte = OP_CALL;
				8: w.first_byte = OP_PUSHQ;
				9: w.first_byte = OP_POPQ;
				default: w.first_byte = {HI_JXX, 4'($urandom_range(15, 0))};
			endcase
			if ($urandom_range(9, 0) != 0) begin
				w.following_bytes[7:4] = 4'($urandom_range(14, 0));
				w.following_bytes[3:0] = 4'($urandom_range(14, 0));
			end
			if (w.first_byte == OP_IRMOVQ && $urandom_range(9, 0) != 0)
				w.following_bytes[7:4] = NO_REG;
		end
		return w;
	endfunction

	task automatic send_window(input window_t w);
		while ($urandom_range(99, 0) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		first_byte <= w.first_byte;
		following_bytes <= w.following_bytes;
		ninth_following_byte <= w.ninth_following_byte;
		bytes_available <= w.bytes_available;
		address <= w.address;
		in_valid <= 1'b1;
		do begin
			@(posedge clk);
		end while (in_stall);
		expected_decodes.push_back(decode_window(w));
	endtask

	task automatic flag_mismatch(input string what, input logic [63:0] got,
			input logic [63:0] want);
		mismatch_count++;
		if (mismatch_count <= MAX_PRINTS)
			$display("%0t: %s differs, got %h want %h", $time, what, got, want);
	endtask

	// output stall: random, or a long hold-off when requested
	always @(posedge clk) begin
		if (hold_seen != hold_reqs) begin
			hold_seen = hold_reqs;
			hold_left = HOLD_CYCLES;
		end
		if (hold_left > 0) begin
			hold_left--;
			out_stall <= 1'b1;
		end else begin
			out_stall <= ($urandom_range(99, 0) < recv_idle_pct);
		end
	end

	always @(posedge clk) begin : check_words
		result_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (expected_decodes.size() == 0) begin
				flag_mismatch("unexpected word", {62'd0, item_kind}, '0);
			end else begin
				want = expected_decodes.pop_front();
				if (item_kind !== want.item_kind)
					flag_mismatch("item_kind", 64'(item_kind), 64'(want.item_kind));
				if (opcode !== want.opcode)
					flag_mismatch("opcode", 64'(opcode), 64'(want.opcode));
				if (reg_a !== want.reg_a)
					flag_mismatch("reg_a", 64'(reg_a), 64'(want.reg_a));
				if (reg_b !== want.reg_b)
					flag_mismatch("reg_b", 64'(reg_b), 64'(want.reg_b));
				if (constant !== want.constant)
					flag_mismatch("constant", constant, want.constant);
				if (length !== want.length)
					flag_mismatch("length", 64'(length), 64'(want.length));
				if (next_address !== want.next_address)
					flag_mismatch("next_address", next_address, want.next_address);
			end
		end
	end

	task automatic test_one_byte_ops;
		send_window(make_window(OP_HALT, '1, 8'hFF, 4'd0, '1));
		send_window(make_window(OP_NOP, '0, 8'h00, 4'd9, 64'h0000_0000_0000_0008));
		send_window(make_window(OP_RET, 64'h0123_4567_89AB_CDEF, 8'h5A, 4'd15,
			64'h8000_0000_0000_0001));
	endtask

	task automatic test_register_ops;
		send_window(make_window({HI_CMOV, 4'h0}, 64'h12, 8'h00, 4'd0, 64'h40));
		send_window(make_window({HI_OPQ, MAX_FN}, 64'hEE, 8'h00, 4'd1, 64'h13));
		send_window(make_window({HI_OPQ, 4'h7}, 64'hFFEE_DDCC_BBAA_9988, 8'h11, 4'd9,
			64'h100));
		send_window(make_window({HI_CMOV, 4'h3}, 64'h1F, 8'h00, 4'd5, 64'h105));
		send_window(make_window(OP_PUSHQ, 64'h3F, 8'h00, 4'd1, 64'h200));
		send_window(make_window(OP_POPQ, 64'hF3, 8'h00, 4'd9, 64'h201));
		send_window(make_window(OP_PUSHQ, 64'hFFFF_FFFF_FFFF_FF00, 8'hFF, 4'd0, 64'h208));
	endtask

	task automatic test_long_ops;
		send_window(make_window(OP_IRMOVQ, 64'hFFFF_FFFF_FFFF_FFFE, 8'hFF, 4'd15,
			64'hFFFF_FFFF_FFFF_FFF8));
		send_window(make_window(OP_IRMOVQ, 64'h0102_0304_0506_0702, 8'h08, 4'd9, 64'h300));
		send_window(make_window(OP_IRMOVQ, 64'h1122_3344_5566_77F1, 8'h88, 4'd8, 64'h308));
		send_window(make_window(OP_RMMOVQ, 64'h0, 8'h00, 4'd9, 64'h310));
		send_window(make_window(OP_MRMOVQ, 64'hAABB_CCDD_EEFF_001F, 8'h99, 4'd9, 64'h31A));
	endtask

	task automatic test_jumps;
		send_window(make_window({HI_JXX, 4'h0}, '1, 8'h00, 4'd8, 64'h400));
		send_window(make_window({HI_JXX, MAX_FN}, 64'h0000_0000_0000_1234, 8'hFF, 4'd12,
			64'h409));
		send_window(make_window({HI_JXX, 4'h7}, 64'h0102_0304_0506_0708, 8'h00, 4'd9,
			64'h410));
		send_window(make_window(OP_CALL, 64'hDEAD_BEEF_0000_0001, 8'h00, 4'd9,
			64'hFFFF_FFFF_FFFF_FFFD));
		send_window(make_window(OP_CALL, 64'h8877_6655_4433_2211, 8'h00, 4'd7, 64'h418));
	endtask

	task automatic test_data_words;
		send_window(make_window(8'hFF, '1, 8'hFF, 4'd7, 64'h500));
		send_window(make_window(8'hFF, '1, 8'hFF, 4'd9, 64'h507));
		send_window(make_window(8'h01, 64'h0706_0504_0302_0100, 8'h00, 4'd6, 64'h508));
		send_window(make_window(8'hC0, 64'h5555_AAAA_5555_AAAA, 8'hAA, 4'd12, 64'h510));
	endtask

	task automatic test_random_stream(input int count, input int send_pct, input int recv_pct);
		send_idle_pct = send_pct;
		recv_idle_pct = recv_pct;
		repeat (count)
			send_window(random_window());
	endtask

	task automatic test_output_holdoff;
		send_idle_pct = 0;
		recv_idle_pct = 0;
		hold_reqs++;
		repeat (30)
			send_window(random_window());
	endtask

	initial begin
		int spins;
		send_idle_pct = 24;
		recv_idle_pct = 56;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_one_byte_ops;
		test_register_ops;
		test_long_ops;
		test_jumps;
		test_data_words;
		test_random_stream(140, 24, 56);
		test_random_stream(140, 56, 24);
		test_random_stream(140, 0, 0);
		test_output_holdoff;
		in_valid <= 1'b0;
		spins = 0;
		while (expected_decodes.size() != 0 && spins < 5000) begin
			@(posedge clk);
			spins++;
		end
		repeat (10) @(posedge clk);
		if (expected_decodes.size() != 0)
			flag_mismatch("words never seen", 64'(expected_decodes.size()), '0);
		if (mismatch_count == 0)
			$display("y86_instruction_classify_decode: match");
		else
			$display("y86_instruction_classify_decode: mismatch");
		$finish;
	end

endmodule

@@ filelist.f @@
+incdir+rtl/core
rtl/core/y86cd_pkg.sv
rtl/core/y86cd_decode.sv
rtl/core/y86_instruction_classify_decode.sv
sim/tb.sv
